/* hw/rtl/nacoa_pkg.sv */
// Shared types and constants for the node-aware CPU ownership allocator.
// Holds request/response payloads, command and status codes, and the
// control structs between the top level and the free-slot search unit.
package nacoa_pkg;

  localparam int unsigned NUM_CPUS_DEF      = 512;
  localparam int unsigned CPUS_PER_NODE_DEF = 64;

  // Bits of the occupancy map examined per search cycle
  localparam int unsigned CHUNK_W    = 64;
  // Slot index width at the largest supported table
  localparam int unsigned SLOT_MAX_W = 12;
  // Width of slot, node-range and limit comparisons
  localparam int unsigned CMP_W      = 16;

  localparam logic [9:0] CPUS_IN_USE_RST = 10'd512;

  localparam logic [1:0] CMD_CLAIM   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FAIL     = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] owner_key;
    logic [2:0]  home_node;
    logic [8:0]  cpu_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] granted_cpu;
    logic       slot_owned;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [CMP_W-1:0] node_lo;
    logic [CMP_W-1:0] node_hi;
    logic [CMP_W-1:0] lim;
  } srch_ctl_t;

  typedef struct packed {
    logic                  done;
    logic                  home_hit;
    logic [SLOT_MAX_W-1:0] home_slot;
    logic                  any_hit;
    logic [SLOT_MAX_W-1:0] any_slot;
  } srch_res_t;

  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [SLOT_MAX_W-1:0] idx;
  } map_upd_t;

endpackage

/* hw/rtl/nacoa_table.sv */
// Owner key memory: one 64-bit key per CPU slot, one write and one
// registered read port, zeroed by a sweep after reset. Uses nacoa_pkg.
module nacoa_table #(
  parameter int unsigned NUM_CPUS = nacoa_pkg::NUM_CPUS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [$clog2(NUM_CPUS)-1:0] rd_addr_i,
  output logic [63:0]                 rd_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(NUM_CPUS)-1:0] wr_addr_i,
  input  logic [63:0]                 wr_data_i,
  output logic                        ready_o
);

  localparam int unsigned AW = $clog2(NUM_CPUS);

  logic [63:0]   mem [NUM_CPUS];
  logic [63:0]   rd_data_q;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;

  // Sweep zeros through every entry before the first request
  always_comb begin
    we    = wr_en_i;
    waddr = wr_addr_i;
    wdata = wr_data_i;
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(NUM_CPUS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_q;

endmodule

/* hw/rtl/nacoa_search.sv */
// Occupancy map and free-slot search: scans the map one chunk per cycle and
// keeps the lowest free slot on the home node and on any node. Uses nacoa_pkg.
module nacoa_search #(
  parameter int unsigned NUM_CPUS = nacoa_pkg::NUM_CPUS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nacoa_pkg::srch_ctl_t  ctl_i,
  input  nacoa_pkg::map_upd_t   upd_i,
  output nacoa_pkg::srch_res_t  res_o
);

  localparam int unsigned CW     = nacoa_pkg::CHUNK_W;
  localparam int unsigned NCHUNK = (NUM_CPUS + CW - 1) / CW;
  localparam int unsigned CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned BITS   = NCHUNK * CW;
  localparam int unsigned BIT_W  = $clog2(BITS);
  localparam int unsigned PE_W   = $clog2(CW);
  localparam int unsigned CMP_W  = nacoa_pkg::CMP_W;
  localparam int unsigned SW     = nacoa_pkg::SLOT_MAX_W;

  logic [BITS-1:0]   owned_q;
  logic              busy_q;
  logic              done_q;
  logic [CIDX_W-1:0] chunk_q;
  logic              home_hit_q;
  logic              any_hit_q;
  logic [SW-1:0]     home_slot_q;
  logic [SW-1:0]     any_slot_q;

  logic [CW-1:0]    word;
  logic [CMP_W-1:0] slot_base;
  logic [CMP_W-1:0] slot;
  logic [CW-1:0]    free_vec;
  logic [CW-1:0]    home_vec;
  logic [PE_W-1:0]  free_pos;
  logic [PE_W-1:0]  home_pos;
  logic             last_chunk;

  always_comb begin
    word      = owned_q[chunk_q * CW +: CW];
    slot_base = CMP_W'(chunk_q) << PE_W;
    slot      = '0;
    free_vec  = '0;
    home_vec  = '0;
    for (int b = 0; b < CW; b++) begin
      slot        = slot_base + CMP_W'(b);
      free_vec[b] = !word[b] && (slot < ctl_i.lim);
      home_vec[b] = free_vec[b] && (slot >= ctl_i.node_lo) && (slot < ctl_i.node_hi);
    end
    // Walk downward so the lowest set bit wins
    free_pos = '0;
    home_pos = '0;
    for (int b = CW - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        free_pos = PE_W'(b);
      end
      if (home_vec[b]) begin
        home_pos = PE_W'(b);
      end
    end
    last_chunk = (chunk_q == CIDX_W'(NCHUNK - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owned_q     <= '0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      chunk_q     <= '0;
      home_hit_q  <= 1'b0;
      any_hit_q   <= 1'b0;
      home_slot_q <= '0;
      any_slot_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (upd_i.set) begin
        owned_q[BIT_W'(upd_i.idx)] <= 1'b1;
      end else if (upd_i.clr) begin
        owned_q[BIT_W'(upd_i.idx)] <= 1'b0;
      end
      if (ctl_i.start) begin
        busy_q     <= 1'b1;
        chunk_q    <= '0;
        home_hit_q <= 1'b0;
        any_hit_q  <= 1'b0;
      end else if (busy_q) begin
        if (!home_hit_q && (home_vec != '0)) begin
          home_hit_q  <= 1'b1;
          home_slot_q <= SW'(slot_base + CMP_W'(home_pos));
        end
        if (!any_hit_q && (free_vec != '0)) begin
          any_hit_q  <= 1'b1;
          any_slot_q <= SW'(slot_base + CMP_W'(free_pos));
        end
        if (last_chunk) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          chunk_q <= chunk_q + CIDX_W'(1);
        end
      end
    end
  end

  assign res_o.done      = done_q;
  assign res_o.home_hit  = home_hit_q;
  assign res_o.home_slot = home_slot_q;
  assign res_o.any_hit   = any_hit_q;
  assign res_o.any_slot  = any_slot_q;

endmodule

/* hw/rtl/node_aware_cpu_ownership_allocator.sv */
// Top level of the node-aware CPU ownership allocator: request sequencer,
// limit register and output register. Uses nacoa_pkg, nacoa_table, nacoa_search.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o with an nacoa_pkg::req_t
//   payload (claim, release or query); each yields one rsp_t on
//   out_valid_o / out_stall_i. A transfer happens when valid is high and
//   stall is low. cfg_we_i writes cfg_wdata_i into the cpus_in_use limit
//   (reset 512); write it only while no request is in flight.
//   One request is in service at a time. A release or query reads the key
//   memory once, checks the registered key in S_CHECK and passes through
//   S_FIN to the output register. A claim scans the occupancy map one
//   64-slot chunk per cycle in S_SCAN, then passes through S_FIN; the scan
//   sets the claim rate. The next request is taken once back in S_IDLE. A
//   claim with a zero key, a release or query with a slot index out of range
//   or an unused command goes straight to S_FIN with no memory access.
//   After reset the key memory is zeroed one entry per cycle through all
//   NUM_CPUS entries, with in_stall_o high; limit writes are taken meanwhile.
//   A finished response sits in the output register while the receiver
//   stalls, and the next request is still accepted; a second finished
//   response then waits in the sequencer until the output register frees.
module node_aware_cpu_ownership_allocator #(
  parameter int unsigned NUM_CPUS      = nacoa_pkg::NUM_CPUS_DEF,
  parameter int unsigned CPUS_PER_NODE = nacoa_pkg::CPUS_PER_NODE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [9:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  nacoa_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nacoa_pkg::rsp_t out_rsp_o
);

  localparam int unsigned AW    = $clog2(NUM_CPUS);
  localparam int unsigned CMP_W = nacoa_pkg::CMP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FIN
  } state_e;

  state_e           state_q;
  nacoa_pkg::req_t  req_q;
  nacoa_pkg::rsp_t  res_q;
  nacoa_pkg::rsp_t  out_rsp_q;
  logic             out_valid_q;
  logic [9:0]       cpus_in_use_q;
  logic [CMP_W-1:0] lim_q;
  logic [CMP_W-1:0] node_lo_q;
  logic [CMP_W-1:0] node_hi_q;
  logic             wr_pend_q;
  logic             wr_set_q;
  logic [AW-1:0]    wr_addr_q;
  logic [63:0]      wr_data_q;

  logic                  tbl_ready;
  logic [63:0]           tbl_rd_data;
  logic                  tbl_rd_en;
  logic                  tbl_wr_en;
  nacoa_pkg::srch_ctl_t  srch_ctl;
  nacoa_pkg::srch_res_t  srch_res;
  nacoa_pkg::map_upd_t   map_upd;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             idx_in_range;
  logic [CMP_W-1:0] lim_d;
  logic [CMP_W-1:0] node_lo_d;
  nacoa_pkg::rsp_t  res_init;
  logic [nacoa_pkg::SLOT_MAX_W-1:0] pick_slot;

  assign in_stall_o = !((state_q == S_IDLE) && tbl_ready);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_FIN) && out_free;

  always_comb begin
    idx_in_range = (CMP_W'(in_req_i.cpu_index) < CMP_W'(NUM_CPUS));
    lim_d        = (CMP_W'(cpus_in_use_q) > CMP_W'(NUM_CPUS)) ?
                   CMP_W'(NUM_CPUS) : CMP_W'(cpus_in_use_q);
    node_lo_d    = CMP_W'(in_req_i.home_node) * CMP_W'(CPUS_PER_NODE);
    pick_slot    = srch_res.home_hit ? srch_res.home_slot : srch_res.any_slot;
    // Requests that finish without a memory access get their status here
    res_init     = '0;
    if ((in_req_i.cmd == nacoa_pkg::CMD_CLAIM) && (in_req_i.owner_key == '0)) begin
      res_init.status = nacoa_pkg::ST_FAIL;
    end else if ((in_req_i.cmd == nacoa_pkg::CMD_RELEASE) && !idx_in_range) begin
      res_init.status = nacoa_pkg::ST_MISMATCH;
    end
  end

  assign tbl_rd_en = in_acc && idx_in_range &&
                     ((in_req_i.cmd == nacoa_pkg::CMD_RELEASE) ||
                      (in_req_i.cmd == nacoa_pkg::CMD_QUERY));
  // Write back only as the response leaves, so the next read sees it
  assign tbl_wr_en = out_load && wr_pend_q;

  assign srch_ctl.start   = in_acc && (in_req_i.cmd == nacoa_pkg::CMD_CLAIM) &&
                            (in_req_i.owner_key != '0);
  assign srch_ctl.node_lo = node_lo_q;
  assign srch_ctl.node_hi = node_hi_q;
  assign srch_ctl.lim     = lim_q;

  assign map_upd.set = tbl_wr_en && wr_set_q;
  assign map_upd.clr = tbl_wr_en && !wr_set_q;
  assign map_upd.idx = nacoa_pkg::SLOT_MAX_W'(wr_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpus_in_use_q <= nacoa_pkg::CPUS_IN_USE_RST;
    end else if (cfg_we_i) begin
      cpus_in_use_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      res_q       <= '0;
      out_rsp_q   <= '0;
      out_valid_q <= 1'b0;
      lim_q       <= '0;
      node_lo_q   <= '0;
      node_hi_q   <= '0;
      wr_pend_q   <= 1'b0;
      wr_set_q    <= 1'b0;
      wr_addr_q   <= '0;
      wr_data_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q     <= in_req_i;
            lim_q     <= lim_d;
            node_lo_q <= node_lo_d;
            node_hi_q <= node_lo_d + CMP_W'(CPUS_PER_NODE);
            res_q     <= res_init;
            wr_pend_q <= 1'b0;
            wr_addr_q <= AW'(in_req_i.cpu_index);
            unique case (in_req_i.cmd)
              nacoa_pkg::CMD_CLAIM: begin
                if (in_req_i.owner_key == '0) begin
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              nacoa_pkg::CMD_RELEASE: begin
                state_q <= idx_in_range ? S_CHECK : S_FIN;
              end
              nacoa_pkg::CMD_QUERY: begin
                state_q <= idx_in_range ? S_CHECK : S_FIN;
              end
              default: begin
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (req_q.cmd == nacoa_pkg::CMD_RELEASE) begin
            if (tbl_rd_data == req_q.owner_key) begin
              wr_pend_q <= 1'b1;
              wr_set_q  <= 1'b0;
              wr_data_q <= '0;
            end else begin
              res_q.status <= nacoa_pkg::ST_MISMATCH;
            end
          end else begin
            res_q.slot_owned <= (tbl_rd_data != '0);
          end
          state_q <= S_FIN;
        end
        S_SCAN: begin
          if (srch_res.done) begin
            if (srch_res.home_hit || srch_res.any_hit) begin
              res_q.granted_cpu <= 9'(pick_slot);
              wr_pend_q         <= 1'b1;
              wr_set_q          <= 1'b1;
              wr_addr_q         <= AW'(pick_slot);
              wr_data_q         <= req_q.owner_key;
            end else begin
              res_q.status <= nacoa_pkg::ST_FAIL;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_rsp_q <= res_q;
            wr_pend_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  nacoa_table #(
    .NUM_CPUS (NUM_CPUS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (AW'(in_req_i.cpu_index)),
    .rd_data_o (tbl_rd_data),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (wr_addr_q),
    .wr_data_i (wr_data_q),
    .ready_o   (tbl_ready)
  );

  nacoa_search #(
    .NUM_CPUS (NUM_CPUS)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (srch_ctl),
    .upd_i  (map_upd),
    .res_o  (srch_res)
  );

  a_no_write_during_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni) tbl_wr_en |-> tbl_ready
  ) else $error("key write while memory sweep is running");

  a_done_only_in_scan: assert property (
    @(posedge clk_i) disable iff (!rst_ni) srch_res.done |-> (state_q == S_SCAN)
  ) else $error("search finished with no claim in service");

  a_check_after_read: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> ($past(state_q) == S_IDLE && $past(tbl_rd_en))
  ) else $error("key check without a memory read the cycle before");

  a_fail_grants_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != nacoa_pkg::ST_DONE) |->
      (out_rsp_o.granted_cpu == '0)
  ) else $error("failed request reports a granted slot");

endmodule
